### hdl/sxd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the STX/ETX deframer.
// No dependencies; used by the channel interfaces and the top level.
package sxd_pkg;

    // Width of the header length field and its parts.
    localparam int LEN_BITS  = 13;
    localparam int HI_BITS   = LEN_BITS - 8;
    localparam int SKIP_BITS = 16;

    // Framing bytes.
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ID_BYTE  = 8'h00;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // Largest accepted payload after reset.
    localparam logic [LEN_BITS-1:0] MAX_PAYLOAD_RESET = {LEN_BITS{1'b1}};

    // End-of-frame verdict codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHECK = 2'd1,
        ST_NO_ETX    = 2'd2,
        ST_TOO_LONG  = 2'd3
    } frame_status_t;

endpackage

### hdl/sxd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the STX/ETX deframer: byte input,
// result output and configuration write. Depends on sxd_pkg.

interface sxd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sxd_result_if;
    logic                              valid;
    logic                              ready;
    logic [7:0]                        payload_byte;
    logic                              is_end;
    sxd_pkg::frame_status_t            frame_status;
    logic [sxd_pkg::LEN_BITS-1:0]      frame_length;
    logic [sxd_pkg::SKIP_BITS-1:0]     skipped_count;

    modport source (output valid, output payload_byte, output is_end,
                    output frame_status, output frame_length,
                    output skipped_count, input ready);
    modport sink   (input valid, input payload_byte, input is_end,
                    input frame_status, input frame_length,
                    input skipped_count, output ready);
endinterface

interface sxd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sxd_pkg::LEN_BITS-1:0]  max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink   (input valid, input max_payload, output ready);
endinterface

### hdl/stx_etx_xor_frame_deframer.sv
`timescale 1ns / 1ps
// Top level of the STX/ETX deframer with XOR check byte.
// Depends on sxd_pkg and the channel interfaces in sxd_if.sv.
//
// Usage:
//   rx_in  - one received byte per transaction (valid/ready).
//   res_out - zero or one result per input byte: a payload byte
//            (is_end = 0) or the end-of-frame verdict (is_end = 1) with
//            status ok, bad check byte, missing ETX or length over limit.
//   cfg    - write of max_payload; always ready, takes effect for bytes
//            processed afterwards. Write it only while the block is idle.
// Pipeline: two register stages, an input byte register and the result
//   register; a byte accepted into the input register is decoded from it,
//   and its result, if any, is loaded when the result register is free.
// Throughput: one byte per cycle when not stalled; the whole per-byte update
//   is one pass from the input register to the state and result registers.
// Stall: while res_out is held off with a result pending, the byte in the
//   input register waits; rx_in still takes one more byte into the empty
//   input register, then drops ready until the result is taken.
// Reset: asynchronous, active low. Clears both stages, sets the hunt state,
//   clears the discard counter and sets max_payload to its maximum.
module stx_etx_xor_frame_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    sxd_byte_if.sink   rx_in,
    sxd_result_if.source res_out,
    sxd_cfg_if.sink    cfg
);

    localparam int LB = sxd_pkg::LEN_BITS;
    localparam int HB = sxd_pkg::HI_BITS;
    localparam int SB = sxd_pkg::SKIP_BITS;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ID      = 3'd1,
        PH_LENHI   = 3'd2,
        PH_LENLO   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5,
        PH_ETX     = 3'd6
    } phase_t;

    // Configuration
    logic [LB-1:0] max_payload_reg;

    // Input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Frame state
    phase_t        phase_reg, phase_next;
    logic [HB-1:0] length_hi_reg, length_hi_next;
    logic [LB-1:0] payload_len_reg, payload_len_next;
    logic [LB-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    check_reg, check_next;
    logic [SB-1:0] discard_reg, discard_next;

    // Result stage
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg;
    logic                   out_end_reg;
    sxd_pkg::frame_status_t out_status_reg;
    logic [LB-1:0]          out_len_reg;
    logic [SB-1:0]          out_skip_reg;

    // Combinational result of the current byte
    logic                   res_valid;
    logic [7:0]             res_byte;
    logic                   res_end;
    sxd_pkg::frame_status_t res_status;

    logic          out_free;
    logic          process;
    logic          in_accept;
    logic [7:0]    b;
    logic [LB-1:0] plen;
    logic [LB-1:0] left_dec;
    logic [1:0]    discard_add;
    logic [SB:0]   discard_sum;
    logic          finish;

    assign out_free  = !out_valid_reg || res_out.ready;
    assign process   = in_valid_reg && out_free;
    assign rx_in.ready = !in_valid_reg || out_free;
    assign in_accept = rx_in.valid && rx_in.ready;
    assign cfg.ready = 1'b1;

    assign b        = in_byte_reg;
    assign plen     = {length_hi_reg, b};
    assign left_dec = bytes_left_reg - {{(LB-1){1'b0}}, 1'b1};

    // Saturating discard count: a broken ID byte can drop two bytes at once.
    assign discard_sum = {1'b0, discard_reg} + {{(SB-1){1'b0}}, discard_add};

    // Per-byte decode: next state and at most one result.
    always_comb
    begin
        phase_next       = phase_reg;
        length_hi_next   = length_hi_reg;
        payload_len_next = payload_len_reg;
        bytes_left_next  = bytes_left_reg;
        xor_next         = xor_reg;
        check_next       = check_reg;
        discard_add      = 2'd0;
        finish           = 1'b0;
        res_valid        = 1'b0;
        res_byte         = 8'h00;
        res_end          = 1'b0;
        res_status       = sxd_pkg::ST_OK;

        unique case (phase_reg)
            PH_ID:
            begin
                if (b == sxd_pkg::ID_BYTE)
                begin
                    xor_next   = b;
                    phase_next = PH_LENHI;
                end
                else if (b == sxd_pkg::STX_BYTE)
                begin
                    // Drop the pending start byte, restart on this one.
                    discard_add = 2'd1;
                end
                else
                begin
                    discard_add = 2'd2;
                    phase_next  = PH_HUNT;
                end
            end
            PH_LENHI:
            begin
                xor_next       = xor_reg ^ b;
                length_hi_next = b[HB-1:0];
                phase_next     = PH_LENLO;
            end
            PH_LENLO:
            begin
                xor_next         = xor_reg ^ b;
                payload_len_next = plen;
                bytes_left_next  = plen;
                if (plen > max_payload_reg)
                begin
                    finish     = 1'b1;
                    res_status = sxd_pkg::ST_TOO_LONG;
                end
                else if (plen == '0)
                begin
                    phase_next = PH_CHECK;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                xor_next        = xor_reg ^ b;
                bytes_left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_CHECK;
                end
                res_valid = 1'b1;
                res_byte  = b;
            end
            PH_CHECK:
            begin
                check_next = b;
                phase_next = PH_ETX;
            end
            PH_ETX:
            begin
                finish = 1'b1;
                // Missing ETX wins over a check byte mismatch.
                if (b != sxd_pkg::ETX_BYTE)
                begin
                    res_status = sxd_pkg::ST_NO_ETX;
                end
                else if (xor_reg != check_reg)
                begin
                    res_status = sxd_pkg::ST_BAD_CHECK;
                end
                else
                begin
                    res_status = sxd_pkg::ST_OK;
                end
            end
            default:
            begin
                // Hunt for the start byte.
                if (b == sxd_pkg::STX_BYTE)
                begin
                    phase_next = PH_ID;
                end
                else
                begin
                    discard_add = 2'd1;
                    phase_next  = PH_HUNT;
                end
            end
        endcase

        if (finish)
        begin
            res_valid  = 1'b1;
            res_end    = 1'b1;
            phase_next = PH_HUNT;
        end

        if (finish)
        begin
            discard_next = '0;
        end
        else if (discard_sum[SB])
        begin
            discard_next = {SB{1'b1}};
        end
        else
        begin
            discard_next = discard_sum[SB-1:0];
        end
    end

    // Stage handshakes: load the input register on accept, empty it when
    // decoded; load the result register only when the byte gives a result.
    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (process)
        begin
            out_valid_next = res_valid;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= sxd_pkg::MAX_PAYLOAD_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_HUNT;
            length_hi_reg   <= '0;
            payload_len_reg <= '0;
            bytes_left_reg  <= '0;
            xor_reg         <= '0;
            check_reg       <= '0;
            discard_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_payload_reg <= cfg.max_payload;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
            begin
                phase_reg       <= phase_next;
                length_hi_reg   <= length_hi_next;
                payload_len_reg <= payload_len_next;
                bytes_left_reg  <= bytes_left_next;
                xor_reg         <= xor_next;
                check_reg       <= check_next;
                discard_reg     <= discard_next;
            end
        end
    end

    // Payload registers: input byte and result fields
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_in.rx_byte;
        end
        if (process && res_valid)
        begin
            out_byte_reg   <= res_byte;
            out_end_reg    <= res_end;
            out_status_reg <= res_status;
            out_len_reg    <= payload_len_next;
            out_skip_reg   <= discard_reg;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.payload_byte  = out_byte_reg;
    assign res_out.is_end        = out_end_reg;
    assign res_out.frame_status  = out_status_reg;
    assign res_out.frame_length  = out_len_reg;
    assign res_out.skipped_count = out_skip_reg;

    // Payload byte results never carry a failure status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_end_reg) |-> (out_status_reg == sxd_pkg::ST_OK))
        else $error("payload result with non-ok status");

    // End results carry a zero payload byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_byte_reg == 8'h00))
        else $error("end result with nonzero payload byte");

    // The payload phase always has bytes left to take.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (bytes_left_reg != '0))
        else $error("payload phase with no bytes left");

    // An end result restarts the hunt with a cleared discard count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && res_valid && res_end) |=>
            (phase_reg == PH_HUNT && discard_reg == '0))
        else $error("frame end did not restart the hunt");

    // A byte waiting on a blocked result stage is held, not lost.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte dropped");

endmodule
